### rtl/altp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// altp_pkg: shared types and codes for the absolute loader tape parser
// Beat layouts for the tape and result channels, and the outcome codes.
// ----------------------------------------------------------------------------
package altp_pkg;

  localparam int unsigned ADDR_BITS = 16;

  // Outcome codes, sticky once not loading
  localparam logic [1:0] ST_LOADING = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_BOTCH   = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // Default target memory size in 16-bit words
  localparam logic [15:0] MEM_WORDS_RESET = 16'd32768;

  typedef struct packed {
    logic [7:0] tape_byte;
    logic       end_of_tape;
  } tape_beat_t;

  typedef struct packed {
    logic                 write_valid;
    logic [ADDR_BITS-1:0] write_address;
    logic [7:0]           write_data;
    logic [1:0]           status;
  } result_beat_t;

endpackage : altp_pkg
`default_nettype wire

### rtl/altp_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// altp_fsm: block parser state and per-byte step logic
// Holds phase, running sum, byte count, load address and outcome; computes
// the result beat for one tape beat and commits the new state on a step.
// ----------------------------------------------------------------------------
module altp_fsm import altp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire tape_beat_t   tape,
  input  wire logic [15:0]  target_words,
  output result_beat_t      result
);

  localparam logic [2:0] PH_SCAN   = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_CNT_LO = 3'd2;
  localparam logic [2:0] PH_CNT_HI = 3'd3;
  localparam logic [2:0] PH_ADR_LO = 3'd4;
  localparam logic [2:0] PH_ADR_HI = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;
  localparam logic [2:0] PH_CKSUM  = 3'd7;

  logic [2:0]           phase, phase_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [15:0]          bytes_left, bytes_left_next;
  logic [ADDR_BITS-1:0] load_address, load_address_next;
  logic [7:0]           low_byte_hold, low_byte_hold_next;
  logic [1:0]           outcome, outcome_next;

  logic [7:0]           sum_add;
  logic [15:0]          word_in;
  logic [15:0]          count_less_hdr;
  logic [15:0]          count_less_one;
  logic                 out_of_range;

  assign sum_add        = running_sum + tape.tape_byte;
  assign word_in        = {tape.tape_byte, low_byte_hold};
  assign count_less_hdr = bytes_left - 16'd6;
  assign count_less_one = bytes_left - 16'd1;
  // byte address must stay below twice the word count
  assign out_of_range   = {1'b0, load_address} >= {target_words, 1'b0};

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    bytes_left_next    = bytes_left;
    load_address_next  = load_address;
    low_byte_hold_next = low_byte_hold;
    outcome_next       = outcome;
    result             = '0;

    if (outcome == ST_LOADING) begin
      if (tape.end_of_tape) begin
        if (phase == PH_SCAN || phase == PH_ZERO) begin
          outcome_next = ST_OK;
        end else begin
          outcome_next = ST_BOTCH;
        end
      end else begin
        case (phase)
          PH_ZERO: begin
            // drop a non-zero byte after 001 and go back to leader scan
            if (tape.tape_byte == 8'd0) begin
              phase_next = PH_CNT_LO;
            end else begin
              phase_next = PH_SCAN;
            end
          end
          PH_CNT_LO, PH_ADR_LO: begin
            running_sum_next   = sum_add;
            low_byte_hold_next = tape.tape_byte;
            phase_next         = phase + 3'd1;
          end
          PH_CNT_HI: begin
            running_sum_next = sum_add;
            bytes_left_next  = word_in;
            phase_next       = PH_ADR_LO;
          end
          PH_ADR_HI: begin
            running_sum_next  = sum_add;
            load_address_next = word_in;
            if (word_in == 16'd1) begin
              outcome_next = ST_OK;
            end else if (bytes_left == 16'd0) begin
              phase_next = PH_SCAN;
            end else begin
              bytes_left_next = count_less_hdr;
              phase_next      = (count_less_hdr == 16'd0) ? PH_CKSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            running_sum_next = sum_add;
            if (out_of_range) begin
              outcome_next = ST_RANGE;
            end else begin
              result.write_valid   = 1'b1;
              result.write_address = load_address;
              result.write_data    = tape.tape_byte;
              load_address_next    = load_address + ADDR_BITS'(1);
              bytes_left_next      = count_less_one;
              if (count_less_one == 16'd0) begin
                phase_next = PH_CKSUM;
              end
            end
          end
          PH_CKSUM: begin
            running_sum_next = sum_add;
            if (sum_add != 8'd0) begin
              outcome_next = ST_BOTCH;
            end else begin
              phase_next = PH_SCAN;
            end
          end
          default: begin
            // leader scan: a 001 opens a block and seeds the sum
            if (tape.tape_byte == 8'd1) begin
              running_sum_next = 8'd1;
              phase_next       = PH_ZERO;
            end else begin
              running_sum_next = 8'd0;
              phase_next       = PH_SCAN;
            end
          end
        endcase
      end
    end

    result.status = outcome_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCAN;
      running_sum   <= '0;
      bytes_left    <= '0;
      load_address  <= '0;
      low_byte_hold <= '0;
      outcome       <= ST_LOADING;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      bytes_left    <= bytes_left_next;
      load_address  <= load_address_next;
      low_byte_hold <= low_byte_hold_next;
      outcome       <= outcome_next;
    end
  end

endmodule : altp_fsm
`default_nettype wire

### rtl/altp_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// altp_skid: two-entry result queue
// Registers result beats; holds one spare slot so a new beat can enter
// while the head beat is stalled.
// ----------------------------------------------------------------------------
module altp_skid import altp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire result_beat_t push_data,
  output logic              full,
  output logic              head_valid,
  output result_beat_t      head,
  input  wire logic         head_stall
);

  result_beat_t tail;
  logic [1:0]   count;
  logic         pop;

  assign pop        = head_valid && !head_stall;
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            count <= 2'd2;
          end else if (!push && pop) begin
            count <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
        default: begin
          count <= 2'd0;
        end
      endcase
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          head <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head <= push_data;
        end else if (push) begin
          tail <= push_data;
        end
      end
      2'd2: begin
        if (pop) begin
          head <= tail;
        end
      end
      default: begin
        head <= head;
      end
    endcase
  end

endmodule : altp_skid
`default_nettype wire

### rtl/absolute_loader_tape_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// absolute_loader_tape_parser_core: absolute loader paper tape parser
// Parses a tape image beat by beat into byte deposits for target memory and
// reports a sticky load outcome (loading, ok, tape botch, out of range).
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | beat
//  ---------+---------------------+--------------------------------------
//  tape     | tape_valid/stall    | tape_beat_t: tape_byte, end_of_tape
//  result   | result_valid/stall  | result_beat_t: write_valid, address,
//           |                     |   data, status
//  cfg      | cfg_valid/ready     | target_words (16 bits)
//
//  One tape beat per cycle while tape_stall is low: the parser state updates
//  at the accepting edge and its single result beat enters the result queue.
//  A two-entry result queue lets one more tape beat in while the head result
//  is stalled; tape_stall rises only when both entries are occupied.
//  Synchronous reset returns to leader scan, outcome loading, target_words
//  32768; cfg writes are taken every cycle.
// ----------------------------------------------------------------------------
module absolute_loader_tape_parser_core import altp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // tape beats in
  input  wire logic         tape_valid,
  output logic              tape_stall,
  input  wire tape_beat_t   tape,
  // result beats out
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_beat_t      result,
  // memory size register
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data
);

  logic         step;
  logic         queue_full;
  logic [15:0]  target_words;
  result_beat_t step_result;

  // Take a tape beat whenever the result queue has a free slot.
  assign tape_stall = queue_full;
  assign step       = tape_valid && !queue_full;

  // Configuration is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_words <= MEM_WORDS_RESET;
    end else if (cfg_valid) begin
      target_words <= cfg_data;
    end
  end

  // Parser: phase, block sum, count and address, step per beat.
  altp_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .tape         (tape),
    .target_words (target_words),
    .result       (step_result)
  );

  // Result register plus skid slot.
  altp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (step_result),
    .full       (queue_full),
    .head_valid (result_valid),
    .head       (result),
    .head_stall (result_stall)
  );

  // A deposit only happens while still loading.
  a_write_while_loading: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.write_valid) |-> (result.status == ST_LOADING))
    else $error("deposit reported with a final status");

  // Idle result beats carry zero address and data.
  a_idle_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.write_valid) |->
      (result.write_address == '0 && result.write_data == 8'd0))
    else $error("non-deposit beat carries address or data");

  // Input backpressure only when a result is waiting to be taken.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    tape_stall |-> result_valid)
    else $error("tape stalled with an empty result queue");

  // A stalled full queue stays full next cycle.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (tape_stall && result_stall) |=> tape_stall)
    else $error("full queue drained while stalled");

endmodule : absolute_loader_tape_parser_core
`default_nettype wire
